/* design/irts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irts_pkg
// Shared types, codes and constants of the i2c register transfer sequencer.
// ----------------------------------------------------------------------------
package irts_pkg;

   // opcodes of a request beat
   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   // start phases of a read transfer
   localparam logic [1:0] PH_NONE    = 2'd0;
   localparam logic [1:0] PH_START   = 2'd1;
   localparam logic [1:0] PH_RESTART = 2'd2;

   // address byte masks
   localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
   localparam logic [7:0] ADDR_RD_BIT  = 8'h01;
   localparam logic [7:0] REG_AUTO_INC = 8'h80;

   // configuration register indexes
   localparam logic [2:0] REG_DIRECTION   = 3'd0;
   localparam logic [2:0] REG_DEVICE_ADDR = 3'd1;
   localparam logic [2:0] REG_REG_ADDR    = 3'd2;
   localparam logic [2:0] REG_TX_BYTE     = 3'd3;
   localparam logic [2:0] REG_BYTE_COUNT  = 3'd4;

   localparam int CSR_ADDR_W = 5;

   typedef struct packed {
      logic       direction;
      logic [7:0] device_addr;
      logic [7:0] reg_addr;
      logic [7:0] tx_byte;
      logic [7:0] byte_count;
   } cfg_type;

   typedef struct packed {
      logic       opcode;
      logic       flag_sb;
      logic       flag_addr;
      logic       flag_txe;
      logic       flag_rxne;
      logic [7:0] data_in;
   } item_type;

   typedef struct packed {
      logic [1:0] start_phase;
      logic [7:0] remaining;
      logic       multi_mode;
      logic       active;
   } state_type;

   typedef struct packed {
      logic       data_write;
      logic [7:0] data_value;
      logic       read_status2;
      logic       gen_start;
      logic       gen_stop;
      logic       ack_on;
      logic       ack_off;
      logic       clear_stop;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       done_res;
      logic       busy_res;
   } result_type;

endpackage

/* design/irts_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irts_csr
// Configuration register file behind the apb-style port.
// ----------------------------------------------------------------------------
module irts_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [irts_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output irts_pkg::cfg_type               cfg
);
   import irts_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_DIRECTION:   cfg_in.direction   = csr_pwdata[0];
            REG_DEVICE_ADDR: cfg_in.device_addr = csr_pwdata[7:0];
            REG_REG_ADDR:    cfg_in.reg_addr    = csr_pwdata[7:0];
            REG_TX_BYTE:     cfg_in.tx_byte     = csr_pwdata[7:0];
            REG_BYTE_COUNT:  cfg_in.byte_count  = csr_pwdata[7:0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         REG_DIRECTION:   csr_prdata[0]   = cfg_ff.direction;
         REG_DEVICE_ADDR: csr_prdata[7:0] = cfg_ff.device_addr;
         REG_REG_ADDR:    csr_prdata[7:0] = cfg_ff.reg_addr;
         REG_TX_BYTE:     csr_prdata[7:0] = cfg_ff.tx_byte;
         REG_BYTE_COUNT:  csr_prdata[7:0] = cfg_ff.byte_count;
         default:         csr_prdata      = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* design/irts_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irts_step
// Event decode: from the current transfer state, the configuration and one
// request beat, forms the controller actions and the next transfer state.
// ----------------------------------------------------------------------------
module irts_step (
   input  irts_pkg::cfg_type    cfg,
   input  irts_pkg::item_type   item,
   input  irts_pkg::state_type  state_cur,
   output irts_pkg::state_type  state_nxt,
   output irts_pkg::result_type res
);
   import irts_pkg::*;

   logic [7:0] rem_dec;

   assign rem_dec = state_cur.remaining - 8'd1;

   always_comb begin
      state_nxt = state_cur;
      res       = '0;
      if (item.opcode == OP_BEGIN) begin
         // begin: load the count, keep the start phase
         state_nxt.remaining = cfg.byte_count;
         state_nxt.active    = 1'b1;
         if (cfg.byte_count > 8'd1) begin
            state_nxt.multi_mode = 1'b1;
         end
      end else if (state_cur.active) begin
         if (!state_cur.multi_mode && !cfg.direction) begin
            // single write: address, register, then data bytes
            priority if (item.flag_sb) begin
               res.data_write = 1'b1;
               res.data_value = cfg.device_addr & ADDR_WR_MASK;
            end else if (item.flag_addr) begin
               res.read_status2 = 1'b1;
               res.data_write   = 1'b1;
               res.data_value   = cfg.reg_addr;
            end else if (item.flag_txe) begin
               if (state_cur.remaining != 8'd0) begin
                  res.data_write      = 1'b1;
                  res.data_value      = cfg.tx_byte;
                  state_nxt.remaining = rem_dec;
               end else begin
                  res.gen_stop  = 1'b1;
                  res.done_res  = 1'b1;
                  state_nxt     = '0;
               end
            end
         end else if (cfg.direction) begin
            // read: register phase, restart, then receive
            priority if (item.flag_sb) begin
               if (state_cur.start_phase == PH_RESTART) begin
                  res.data_write = 1'b1;
                  res.data_value = cfg.device_addr | ADDR_RD_BIT;
               end else if (state_cur.start_phase == PH_NONE) begin
                  res.data_write        = 1'b1;
                  res.data_value        = cfg.device_addr & ADDR_WR_MASK;
                  state_nxt.start_phase = PH_START;
               end
            end else if (item.flag_addr) begin
               if (state_cur.start_phase == PH_START) begin
                  res.read_status2 = 1'b1;
                  res.data_write   = 1'b1;
                  res.data_value   = state_cur.multi_mode ?
                                     (cfg.reg_addr | REG_AUTO_INC) : cfg.reg_addr;
               end else if (state_cur.start_phase == PH_RESTART) begin
                  res.read_status2 = 1'b1;
                  if (state_cur.multi_mode) begin
                     res.ack_on     = 1'b1;
                     res.clear_stop = 1'b1;
                  end else begin
                     res.gen_stop = 1'b1;
                     res.ack_off  = 1'b1;
                  end
               end
            end else if (item.flag_txe && state_cur.start_phase == PH_START) begin
               res.gen_start         = 1'b1;
               state_nxt.start_phase = PH_RESTART;
            end else if (item.flag_rxne) begin
               if (!state_cur.multi_mode) begin
                  res.rx_valid = 1'b1;
                  res.rx_byte  = item.data_in;
                  res.done_res = 1'b1;
                  state_nxt    = '0;
               end else if (state_cur.remaining > 8'd1) begin
                  res.rx_valid        = 1'b1;
                  res.rx_byte         = item.data_in;
                  state_nxt.remaining = rem_dec;
                  // nack the last byte once only one is left
                  if (rem_dec == 8'd1) begin
                     res.ack_off  = 1'b1;
                     res.gen_stop = 1'b1;
                  end
               end else if (state_cur.remaining == 8'd1) begin
                  res.rx_valid = 1'b1;
                  res.rx_byte  = item.data_in;
                  res.done_res = 1'b1;
                  state_nxt    = '0;
               end
            end
         end
      end
      res.busy_res = state_nxt.active;
   end

endmodule

/* design/i2c_register_transfer_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_transfer_sequencer
// Steps an i2c master controller through a register-addressed transfer.
// ----------------------------------------------------------------------------
// Usage: set direction, device_addr, reg_addr, tx_byte and byte_count through
// the csr_ apb port while the block is idle, then send a begin beat
// (req_tuser = 0) followed by one event beat (req_tuser = 1) per controller
// interrupt, carrying the status flags and the received byte. Every request
// beat yields exactly one response beat with the controller actions, any
// received byte, busy, and rsp_tlast set on the beat that ends the transfer.
// An accepted request beat is held in the input register, then passes
// through the event decode into the output register, which drives the
// response. Throughput is one beat per cycle while rsp_tready is high; the
// transfer state is updated in the same cycle its beat moves into the
// output register, so consecutive beats chain without bubbles. When
// rsp_tready is low the response holds and the input register keeps one
// more beat; req_tready drops only when both are full. Reset clears the
// transfer state and the configuration and empties both pipeline
// registers.
// ----------------------------------------------------------------------------
module i2c_register_transfer_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: flag_sb, flag_addr, flag_txe, flag_rxne, data_in[7:0], zero pad
   input  logic [15:0]                     req_tdata,
   // tuser: opcode
   input  logic                            req_tuser,
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: data_write, data_value[7:0], read_status2, gen_start, gen_stop,
   //        ack_on, ack_off, clear_stop, rx_valid, rx_byte[7:0], busy_res, pad
   output logic [31:0]                     rsp_tdata,
   // tlast: done_res
   output logic                            rsp_tlast,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [irts_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import irts_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   item_type   item_in;
   logic       in_valid_ff;
   logic       in_valid_in;
   result_type out_ff;
   result_type out_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   state_type  state_ff;
   state_type  state_in;
   state_type  state_nxt;
   result_type res;
   logic       advance;
   logic       req_beat;

   irts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   irts_step u_step (
      .cfg       (cfg),
      .item      (item_ff),
      .state_cur (state_ff),
      .state_nxt (state_nxt),
      .res       (res)
   );

   // handshake
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_beat   = req_tvalid & req_tready;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_beat) begin
         in_valid_in       = 1'b1;
         item_in.opcode    = req_tuser;
         item_in.flag_sb   = req_tdata[0];
         item_in.flag_addr = req_tdata[1];
         item_in.flag_txe  = req_tdata[2];
         item_in.flag_rxne = req_tdata[3];
         item_in.data_in   = req_tdata[11:4];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // output register and transfer state
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      state_in     = state_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = res;
         state_in     = state_nxt;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
   end

   // response packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.done_res;
   assign rsp_tdata  = {7'd0,
                        out_ff.busy_res,
                        out_ff.rx_byte,
                        out_ff.rx_valid,
                        out_ff.clear_stop,
                        out_ff.ack_off,
                        out_ff.ack_on,
                        out_ff.gen_stop,
                        out_ff.gen_start,
                        out_ff.read_status2,
                        out_ff.data_value,
                        out_ff.data_write};

   // busy on each beat reflects the state it leaves behind
   a_busy_tracks_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_ff.busy_res == state_ff.active))
      else $error("busy_res does not match transfer state");

   // a completing beat never reports busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> !out_ff.busy_res)
      else $error("done beat reports busy");

   // idle state carries no leftover phase, count or mode
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !state_ff.active |-> (state_ff.start_phase == PH_NONE &&
                            state_ff.remaining == 8'd0 && !state_ff.multi_mode))
      else $error("idle with stale transfer state");

   // a received byte and a data write never share a beat
   a_rx_excl_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_ff.rx_valid && out_ff.data_write))
      else $error("rx byte and data write in one beat");

endmodule
